@@ sv/tkp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkp_pkg - shared types and constants of the top-k peak tracker
// Entry layout, cell control word, moment accumulators and field widths.
// ----------------------------------------------------------------------------
package tkp_pkg;

	// number of cells in the sorted chain
	localparam int LIST_DEPTH = 16;

	// fixed field widths
	localparam int MAG_W   = 24;
	localparam int POS_W   = 16;
	localparam int RANK_W  = 6;
	localparam int COUNT_W = 32;
	localparam int SUM_W   = 56;
	localparam int SQ_W    = 64;

	// report slot counter
	localparam int CNT_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(LIST_DEPTH - 1);

	// packed stream widths
	localparam int S_FIELDS_W = MAG_W + 2 * POS_W;
	localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = RANK_W + 2 * POS_W + MAG_W + COUNT_W + SUM_W + SQ_W;
	localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_USER_W   = 2;

	// one slot of the peak list
	typedef struct packed {
		logic             valid;
		logic [MAG_W-1:0] value;
		logic [POS_W-1:0] freq;
		logic [POS_W-1:0] tpos;
	} entry_t;

	// broadcast control to every cell
	typedef struct packed {
		logic   ins;     // sample word accepted: insert
		logic   shift;   // report word taken: shift towards head
		entry_t sample;  // incoming sample
		entry_t head;    // entry currently at the head of the chain
	} cell_ctl_t;

	// running moments
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [SUM_W-1:0]   sum;
		logic [SQ_W-1:0]    squares;
	} moments_t;

	// positions within plus or minus one, no wrap
	function automatic logic near_pos(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
		logic [POS_W:0] ax;
		logic [POS_W:0] bx;
		ax = {1'b0, a};
		bx = {1'b0, b};
		return (ax == bx) || (ax == bx + 1'b1) || (bx == ax + 1'b1);
	endfunction

endpackage

@@ sv/tkp_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkp_cell - one slot of the sorted peak chain
// Takes a new sample or its upper neighbour's entry on insertion, takes its
// lower neighbour's entry on report shift, and tracks nearness to the head.
// ----------------------------------------------------------------------------
module tkp_cell import tkp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      up_take,     // upper neighbour takes the sample or its own upper
	input  entry_t    up_entry,
	input  entry_t    down_entry,
	input  logic      down_near,   // lower neighbour's near flag, head compare included
	output logic      take,
	output entry_t    entry,
	output logic      near_q,
	output logic      near_out
);

	entry_t           ent_d;
	logic             valid_q;
	logic [MAG_W-1:0] value_q;
	logic [POS_W-1:0] freq_q;
	logic [POS_W-1:0] tpos_q;

	// current entry
	assign entry = '{valid: valid_q, value: value_q, freq: freq_q, tpos: tpos_q};

	// sample belongs here or below: slot empty or strictly exceeded
	assign take = !valid_q || (ctl.sample.value > value_q);

	// next entry contents
	always_comb begin
		ent_d = entry;
		if (ctl.shift) begin
			ent_d = down_entry;
		end else if (ctl.ins && take) begin
			ent_d = up_take ? up_entry : ctl.sample;
		end
	end

	// valid and near flags, an empty upper slot moves down still empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			near_q  <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= down_entry.valid;
			near_q  <= down_near;
		end else if (ctl.ins && take) begin
			valid_q <= ent_d.valid;
			near_q  <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		value_q <= ent_d.value;
		freq_q  <= ent_d.freq;
		tpos_q  <= ent_d.tpos;
	end

	// head is a higher-ranked valid neighbour
	assign near_out = near_q || (valid_q && ctl.head.valid &&
		near_pos(ctl.head.freq, freq_q) && near_pos(ctl.head.tpos, tpos_q));

endmodule

@@ sv/tkp_moments.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkp_moments - running count, sum and saturating sum of squares
// Square is registered first, then the wide accumulate registers the sums.
// ----------------------------------------------------------------------------
module tkp_moments import tkp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_en,
	input  logic [MAG_W-1:0] mag,
	input  logic             clear,
	output moments_t         mom
);

	logic                  v_s1;
	logic [MAG_W-1:0]      mag_s1;
	logic [2*MAG_W-1:0]    sq_s1;
	moments_t              mom_q;
	logic [SQ_W:0]         sq_add;

	// stage 1: square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= sample_en;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= mag;
		sq_s1  <= mag * mag;
	end

	// stage 2: accumulate with saturation on squares
	assign sq_add = {1'b0, mom_q.squares} + (SQ_W + 1)'(sq_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mom_q <= '0;
		end else if (clear) begin
			mom_q <= '0;
		end else if (v_s1) begin
			mom_q.count   <= mom_q.count + 1'b1;
			mom_q.sum     <= mom_q.sum + SUM_W'(mag_s1);
			mom_q.squares <= sq_add[SQ_W] ? {SQ_W{1'b1}} : sq_add[SQ_W-1:0];
		end
	end

	assign mom = mom_q;

endmodule

@@ sv/top_k_peak_tracker_with_moments.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_peak_tracker_with_moments - sorted top-k peak list with moments
// Chain of compare-and-insert cells plus running count, sum and squares.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while a group is open: each cell compares
// the broadcast sample with its own entry and the chain inserts it, so
// insertion never stalls the input. The word that ends a group (tlast) is
// followed by a flush state in which the squaring pipeline settles, then
// LIST_DEPTH report words, one per cycle while tready is held, read from
// the head cell as the chain shifts up. The input is not ready from the
// final sample until the last report word is taken. Empty entries fill in
// from the tail as the report shifts, so the next group starts clean with
// no extra pass.
// ----------------------------------------------------------------------------
module top_k_peak_tracker_with_moments import tkp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // magnitude, frequency index, time index
	input  logic                s_tlast,   // group_end
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // rank, peak_freq, peak_time, peak_value,
	                                       // sample_count, amplitude_sum, square_sum, pad
	output logic [M_USER_W-1:0] m_tuser,   // peak_valid, isolated
	output logic                m_tlast    // report_last
);

	typedef enum logic [1:0] {ST_ACCUM, ST_FLUSH, ST_REPORT} state_t;

	localparam int SECOND = (LIST_DEPTH > 1) ? 1 : 0;

	state_t           state_q;
	logic [CNT_W-1:0] slot_q;

	cell_ctl_t ctl;
	entry_t    ent      [LIST_DEPTH];
	logic      take     [LIST_DEPTH];
	logic      near     [LIST_DEPTH];
	logic      near_out [LIST_DEPTH];
	moments_t  mom;
	logic      s_hs;
	logic      m_hs;
	entry_t    head;
	entry_t    tail_fill;

	assign s_tready = (state_q == ST_ACCUM);
	assign m_tvalid = (state_q == ST_REPORT);
	assign s_hs     = s_tvalid && s_tready;
	assign m_hs     = m_tvalid && m_tready;
	assign head     = ent[0];
	assign tail_fill = '0;

	// broadcast control
	always_comb begin
		ctl.ins          = s_hs;
		ctl.shift        = m_hs;
		ctl.sample.valid = 1'b1;
		ctl.sample.value = s_tdata[MAG_W-1:0];
		ctl.sample.freq  = s_tdata[MAG_W+POS_W-1:MAG_W];
		ctl.sample.tpos  = s_tdata[MAG_W+2*POS_W-1:MAG_W+POS_W];
		ctl.head         = head;
	end

	// cell chain
	for (genvar j = 0; j < LIST_DEPTH; j++) begin : g_cell
		logic   up_take_w;
		entry_t up_entry_w;
		entry_t down_entry_w;
		logic   down_near_w;

		if (j == 0) begin : g_first
			assign up_take_w  = 1'b0;
			assign up_entry_w = ctl.sample;
		end else begin : g_mid
			assign up_take_w  = take[j-1];
			assign up_entry_w = ent[j-1];
		end

		if (j == LIST_DEPTH - 1) begin : g_last
			assign down_entry_w = tail_fill;
			assign down_near_w  = 1'b0;
		end else begin : g_inner
			assign down_entry_w = ent[j+1];
			assign down_near_w  = near_out[j+1];
		end

		tkp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.up_take    (up_take_w),
			.up_entry   (up_entry_w),
			.down_entry (down_entry_w),
			.down_near  (down_near_w),
			.take       (take[j]),
			.entry      (ent[j]),
			.near_q     (near[j]),
			.near_out   (near_out[j])
		);
	end

	// moments
	tkp_moments u_moments (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_en (s_hs),
		.mag       (s_tdata[MAG_W-1:0]),
		.clear     (m_hs && m_tlast),
		.mom       (mom)
	);

	// group sequencing and report slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			slot_q  <= '0;
		end else begin
			unique case (state_q)
				ST_ACCUM: begin
					if (s_hs && s_tlast) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					if (m_hs) begin
						if (slot_q == LAST_SLOT) begin
							slot_q  <= '0;
							state_q <= ST_ACCUM;
						end else begin
							slot_q <= slot_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_ACCUM;
				end
			endcase
		end
	end

	// report word from the head cell
	always_comb begin
		m_tdata = '0;
		m_tdata[RANK_W-1:0] = RANK_W'(slot_q);
		m_tdata[RANK_W+POS_W-1:RANK_W] = head.valid ? head.freq : '0;
		m_tdata[RANK_W+2*POS_W-1:RANK_W+POS_W] = head.valid ? head.tpos : '0;
		m_tdata[RANK_W+2*POS_W+MAG_W-1:RANK_W+2*POS_W] = head.valid ? head.value : '0;
		m_tdata[M_FIELDS_W-1:RANK_W+2*POS_W+MAG_W] = {mom.squares, mom.sum, mom.count};
		m_tuser[0] = head.valid;
		m_tuser[1] = head.valid && !near[0];
		m_tlast    = (slot_q == LAST_SLOT);
	end

	// checks
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready during report");

	a_end_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_hs && s_tlast) |=> !s_tready)
		else $error("input still ready after group end");

	a_back_to_accum: assert property (@(posedge clk) disable iff (!arst_n)
		(m_hs && m_tlast) |=> s_tready)
		else $error("input not reopened after report");

	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		ent[SECOND].valid |-> ent[0].valid)
		else $error("empty slot above a filled one");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		ent[SECOND].valid |-> (ent[0].value >= ent[SECOND].value))
		else $error("head smaller than second entry");

endmodule

@@ tb/sv/top_k_peak_tracker_with_moments_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_peak_tracker_with_moments_tb - self-checking bench of the peak tracker
// Streams sample words in groups and predicts each report: the sorted top-k
// list with tie order, isolation flags and the running count, sum and
// saturating square sum. Every report word is checked field by field against
// the oldest prediction; random tests let both stream sides idle and stall.
// ----------------------------------------------------------------------------
module top_k_peak_tracker_with_moments_tb import tkp_pkg::*; ();

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_SLACK  = 40;
	localparam int FULL_SAMPLES = 24;

	// report word layout, lowest bit first
	localparam int FREQ_LSB  = RANK_W;
	localparam int TIME_LSB  = FREQ_LSB + POS_W;
	localparam int VALUE_LSB = TIME_LSB + POS_W;
	localparam int COUNT_LSB = VALUE_LSB + MAG_W;
	localparam int SUM_LSB   = COUNT_LSB + COUNT_W;
	localparam int SQ_LSB    = SUM_LSB + SUM_W;
	localparam int USER_VALID    = 0;
	localparam int USER_ISOLATED = 1;

	typedef enum {MAG_WIDE, MAG_NARROW, MAG_EDGE} mag_mode_t;

	// one predicted report word
	typedef struct {
		logic [RANK_W-1:0]  rank;
		logic               valid;
		logic [POS_W-1:0]   freq;
		logic [POS_W-1:0]   tpos;
		logic [MAG_W-1:0]   value;
		logic               isolated;
		logic [COUNT_W-1:0] count;
		logic [SUM_W-1:0]   sum;
		logic [SQ_W-1:0]    squares;
		logic               last;
	} report_word_t;

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic                s_tlast  = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [M_USER_W-1:0] m_tuser;
	logic                m_tlast;

	// predictor state
	entry_t       peak_list [LIST_DEPTH];
	moments_t     group_moments;
	report_word_t pending_reports[$];

	int err_count      = 0;
	int cycle_count    = 0;
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;

	top_k_peak_tracker_with_moments u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// random receiver stall
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// positions within plus or minus one, plain unsigned
	function automatic bit positions_adjacent(input logic [POS_W-1:0] a,
	                                          input logic [POS_W-1:0] b);
		int diff;
		diff = int'(a) - int'(b);
		return (diff >= -1) && (diff <= 1);
	endfunction

	// update moments and the sorted list; on group end queue the whole report
	task automatic track_sample(input logic [MAG_W-1:0] mag, input logic [POS_W-1:0] f_in,
	                            input logic [POS_W-1:0] t_in, input logic group_end);
		logic [SQ_W-1:0] sq;
		int              slot;
		int              k;
		int              p;
		report_word_t    word;
		sq = SQ_W'(mag) * SQ_W'(mag);
		group_moments.count = group_moments.count + 1'b1;
		group_moments.sum   = group_moments.sum + SUM_W'(mag);
		if (group_moments.squares > ~sq)
			group_moments.squares = '1;
		else
			group_moments.squares = group_moments.squares + sq;

		// ties keep the older entry ahead
		slot = 0;
		while (slot < LIST_DEPTH && peak_list[slot].valid && mag <= peak_list[slot].value)
			slot++;
		if (slot < LIST_DEPTH) begin
			for (k = LIST_DEPTH - 1; k > slot; k--)
				peak_list[k] = peak_list[k - 1];
			peak_list[slot] = '{valid: 1'b1, value: mag, freq: f_in, tpos: t_in};
		end

		if (group_end) begin
			for (k = 0; k < LIST_DEPTH; k++) begin
				word.rank     = RANK_W'(k);
				word.valid    = peak_list[k].valid;
				word.freq     = peak_list[k].valid ? peak_list[k].freq  : '0;
				word.tpos     = peak_list[k].valid ? peak_list[k].tpos  : '0;
				word.value    = peak_list[k].valid ? peak_list[k].value : '0;
				word.isolated = peak_list[k].valid;
				for (p = 0; p < k; p++) begin
					if (peak_list[p].valid &&
					    positions_adjacent(peak_list[p].freq, peak_list[k].freq) &&
					    positions_adjacent(peak_list[p].tpos, peak_list[k].tpos))
						word.isolated = 1'b0;
				end
				word.count   = group_moments.count;
				word.sum     = group_moments.sum;
				word.squares = group_moments.squares;
				word.last    = (k == LIST_DEPTH - 1);
				pending_reports.push_back(word);
			end
			for (k = 0; k < LIST_DEPTH; k++)
				peak_list[k] = '0;
			group_moments = '0;
		end
	endtask

	// send one sample word, with a random idle gap in front
	task automatic send_sample(input logic [MAG_W-1:0] mag, input logic [POS_W-1:0] f_in,
	                           input logic [POS_W-1:0] t_in, input logic group_end);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_DATA_W'({t_in, f_in, mag});
		s_tlast  <= group_end;
		do
			@(posedge clk);
		while (!s_tready);
		track_sample(mag, f_in, t_in, group_end);
	endtask

	// hold the sender until every predicted report word has come back
	task automatic wait_reports_drained();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [SQ_W-1:0] want,
	                           input logic [SQ_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	// compare each report word with the oldest prediction
	always @(posedge clk) begin
		report_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$error("report word with no prediction waiting: rank %0d",
				       m_tdata[RANK_W-1:0]);
				err_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("rank",          want.rank,     m_tdata[0 +: RANK_W]);
				check_field("peak_valid",    want.valid,    m_tuser[USER_VALID]);
				check_field("peak_freq",     want.freq,     m_tdata[FREQ_LSB +: POS_W]);
				check_field("peak_time",     want.tpos,     m_tdata[TIME_LSB +: POS_W]);
				check_field("peak_value",    want.value,    m_tdata[VALUE_LSB +: MAG_W]);
				check_field("isolated",      want.isolated, m_tuser[USER_ISOLATED]);
				check_field("sample_count",  want.count,    m_tdata[COUNT_LSB +: COUNT_W]);
				check_field("amplitude_sum", want.sum,      m_tdata[SUM_LSB +: SUM_W]);
				check_field("square_sum",    want.squares,  m_tdata[SQ_LSB +: SQ_W]);
				check_field("report_last",   want.last,     m_tlast);
			end
		end
	end

	// single-sample groups at the field extremes, zero filling an empty slot
	task automatic test_single_extremes();
		send_sample('1, '1, '1, 1'b1);
		send_sample('0, '0, '0, 1'b1);
		wait_reports_drained();
	endtask

	// equal values keep arrival order; neighbours clear the isolated flag
	task automatic test_ties_and_adjacency();
		send_sample(24'd500, 16'd10, 16'd10, 1'b0);
		send_sample(24'd500, 16'd20, 16'd20, 1'b0);
		send_sample(24'd900, 16'd100, 16'd100, 1'b0);
		send_sample(24'd800, 16'd101, 16'd99, 1'b0);
		send_sample(24'd700, 16'd102, 16'd100, 1'b0);
		// no wrap between the lowest and highest position
		send_sample(24'd600, 16'd0, 16'd5, 1'b0);
		send_sample(24'd600, 16'hFFFF, 16'd5, 1'b1);
		wait_reports_drained();
	endtask

	// full list: a new head pushes the tail out, a low sample is dropped
	task automatic test_list_overflow();
		int i;
		for (i = 0; i < LIST_DEPTH; i++)
			send_sample(MAG_W'(1000 - 10 * i), POS_W'(4 * i), POS_W'(4 * i), 1'b0);
		send_sample(24'd2000, 16'd300, 16'd300, 1'b0);
		send_sample(24'd1, 16'd400, 16'd400, 1'b1);
		wait_reports_drained();
	endtask

	// full-scale samples tied all the way, more than the list holds
	task automatic test_full_scale_group();
		int i;
		for (i = 0; i < FULL_SAMPLES; i++)
			send_sample('1, POS_W'(i), POS_W'(i), i == FULL_SAMPLES - 1);
		wait_reports_drained();
	endtask

	// random groups, mostly short, some overfilling the list
	task automatic test_random_groups(input int n_items, input int idle_pct,
	                                  input int stall_pct);
		int               sent;
		int               group_len;
		int               i;
		bit               clustered;
		mag_mode_t        mag_mode;
		logic [MAG_W-1:0] mag;
		logic [POS_W-1:0] base_f;
		logic [POS_W-1:0] base_t;
		logic [POS_W-1:0] f_pos;
		logic [POS_W-1:0] t_pos;
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			group_len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(16, 1);
			mag_mode  = mag_mode_t'($urandom_range(2));
			clustered = $urandom_range(1);
			base_f    = POS_W'($urandom);
			base_t    = POS_W'($urandom);
			for (i = 0; i < group_len; i++) begin
				case (mag_mode)
					MAG_WIDE: begin
						mag = MAG_W'($urandom);
					end
					MAG_NARROW: begin
						mag = MAG_W'($urandom_range(7));
					end
					default: begin
						case ($urandom_range(3))
							0: mag = '0;
							1: mag = '1;
							2: mag = MAG_W'(1);
							default: mag = {MAG_W{1'b1}} - 1'b1;
						endcase
					end
				endcase
				if (clustered) begin
					f_pos = base_f + POS_W'($urandom_range(3));
					t_pos = base_t + POS_W'($urandom_range(3));
				end else begin
					f_pos = POS_W'($urandom);
					t_pos = POS_W'($urandom);
				end
				send_sample(mag, f_pos, t_pos, i == group_len - 1);
			end
			sent += group_len;
		end
		wait_reports_drained();
	endtask

	// test sequence
	initial begin
		group_moments = '0;
		for (int k = 0; k < LIST_DEPTH; k++)
			peak_list[k] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_extremes();
		test_ties_and_adjacency();
		test_list_overflow();
		test_full_scale_group();
		test_random_groups(70, 0, 0);
		test_random_groups(65, 63, 0);
		test_random_groups(65, 0, 63);
		test_random_groups(65, 14, 14);

		if (pending_reports.size() != 0) begin
			$error("%0d predicted report words never arrived", pending_reports.size());
			err_count++;
		end
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
